@@ design/svg_well_formed_checker_macros.svh @@
// assertion macros shared by the svg well-formed checker rtl
// expects signals clk and rst_n in the scope of each use
`ifndef SVG_WELL_FORMED_CHECKER_MACROS_SVH
`define SVG_WELL_FORMED_CHECKER_MACROS_SVH

// property checked on every rising edge outside reset
`define WFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent this cycle implies consequent on the next cycle
`define WFC_IMPLY_NEXT(lbl, ante, cons, msg) \
  `WFC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ design/svg_wfc_pkg.sv @@
// shared constants, byte classes and result struct for the svg well-formed checker
// no dependencies
package svg_wfc_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int NAME_BYTES_DEF  = 32;

  localparam logic [7:0] CH_LT    = 8'h3C;  // <
  localparam logic [7:0] CH_GT    = 8'h3E;  // >
  localparam logic [7:0] CH_BANG  = 8'h21;  // !
  localparam logic [7:0] CH_DASH  = 8'h2D;  // -
  localparam logic [7:0] CH_SLASH = 8'h2F;  // /
  localparam logic [7:0] CH_SQUOT = 8'h27;  // '
  localparam logic [7:0] CH_DQUOT = 8'h22;  // "

  localparam logic [1:0] ROOT_LEN = 2'd3;

  typedef struct packed {
    logic done;
    logic well_formed;
  } wfc_res_t;

  function automatic logic is_name_byte(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h3A || b == CH_DASH || b == 8'h5F;
  endfunction

  function automatic logic is_space_byte(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // bytes of the required root name
  function automatic logic [7:0] root_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h73;
      2'd1: r = 8'h76;
      2'd2: r = 8'h67;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ design/svg_wfc_ram.sv @@
// simple dual-port synchronous ram, registered read, write data forwarded
// no dependencies
module svg_wfc_ram #(
  parameter int DW = 8,
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [(1 << AW)];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // same-address write in this cycle wins over the stored word
    if (wr_en && wr_addr == rd_addr) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/svg_wfc_scan.sv @@
// byte scanner: tag/comment state, open-name stack in two rams, verdict on last byte
// depends on svg_wfc_pkg, svg_wfc_ram and the assertion macro header
`include "svg_well_formed_checker_macros.svh"

module svg_wfc_scan #(
  parameter int STACK_DEPTH = 64,
  parameter int NAME_BYTES  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            byte_value,
  input  logic                  last_byte,
  output svg_wfc_pkg::wfc_res_t res
);
  import svg_wfc_pkg::*;

  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int PW  = $clog2(NAME_BYTES + 1);
  localparam int NAW = $clog2(NAME_BYTES);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [2:0] M_OUTSIDE = 3'd0;
  localparam logic [2:0] M_LT      = 3'd1;
  localparam logic [2:0] M_BANG    = 3'd2;
  localparam logic [2:0] M_BANG_D  = 3'd3;
  localparam logic [2:0] M_COMMENT = 3'd4;
  localparam logic [2:0] M_CLOSE   = 3'd5;
  localparam logic [2:0] M_NAME    = 3'd6;
  localparam logic [2:0] M_BODY    = 3'd7;

  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_SINGLE = 2'd1;
  localparam logic [1:0] Q_DOUBLE = 2'd2;

  logic [2:0]     mode_r, mode_nxt;
  logic [1:0]     quote_r, quote_nxt;
  logic [1:0]     cmatch_r, cmatch_nxt;
  logic [SCW-1:0] sc_r, sc_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic           closing_r, closing_nxt;
  logic           differs_r, differs_nxt;
  logic           slash_r, slash_nxt;
  logic           root_r, root_nxt;
  logic           failed_r, failed_nxt;

  logic               name_we, len_we;
  logic [SAW+NAW-1:0] name_waddr, name_raddr;
  logic [7:0]         name_rd;
  logic [SAW-1:0]     len_waddr, rd_row;
  logic [NAW-1:0]     rd_pos;
  logic [PW-1:0]      len_rd;
  logic [SCW-1:0]     sc_m1;
  logic               verdict;

  always_comb begin
    logic do_take;
    logic do_body;
    logic body_ends;
    mode_nxt    = mode_r;
    quote_nxt   = quote_r;
    cmatch_nxt  = cmatch_r;
    sc_nxt      = sc_r;
    pos_nxt     = pos_r;
    closing_nxt = closing_r;
    differs_nxt = differs_r;
    slash_nxt   = slash_r;
    root_nxt    = root_r;
    failed_nxt  = failed_r;
    name_we     = 1'b0;
    len_we      = 1'b0;
    name_waddr  = {sc_r[SAW-1:0], pos_r[NAW-1:0]};
    len_waddr   = sc_r[SAW-1:0];
    do_take     = 1'b0;
    do_body     = 1'b0;
    body_ends   = 1'b0;

    if (step && !failed_r) begin
      case (mode_r)
        M_OUTSIDE: begin
          if (byte_value == CH_LT) mode_nxt = M_LT;
        end
        M_LT: begin
          if (byte_value == CH_BANG) begin
            mode_nxt = M_BANG;
          end else if (byte_value == CH_SLASH) begin
            closing_nxt = 1'b1;
            mode_nxt    = M_CLOSE;
          end else if (is_name_byte(byte_value)) begin
            closing_nxt = 1'b0;
            do_take     = 1'b1;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        M_BANG: begin
          if (byte_value == CH_DASH) mode_nxt = M_BANG_D;
          else failed_nxt = 1'b1;
        end
        M_BANG_D: begin
          if (byte_value == CH_DASH) begin
            mode_nxt   = M_COMMENT;
            cmatch_nxt = 2'd0;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        M_COMMENT: begin
          if (byte_value == CH_DASH) begin
            if (cmatch_r < 2'd2) cmatch_nxt = cmatch_r + 2'd1;
          end else if (byte_value == CH_GT && cmatch_r == 2'd2) begin
            mode_nxt   = M_OUTSIDE;
            cmatch_nxt = 2'd0;
          end else begin
            cmatch_nxt = 2'd0;
          end
        end
        M_CLOSE: begin
          if (is_name_byte(byte_value)) do_take = 1'b1;
          else failed_nxt = 1'b1;
        end
        M_NAME: begin
          if (is_name_byte(byte_value)) begin
            do_take = 1'b1;
          end else begin
            mode_nxt = M_BODY;
            do_body  = 1'b1;
          end
        end
        M_BODY: begin
          do_body = 1'b1;
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase

      // first name byte of a tag starts a fresh name
      if (do_take && mode_r != M_NAME) begin
        pos_nxt     = '0;
        differs_nxt = 1'b0;
        slash_nxt   = 1'b0;
        quote_nxt   = Q_NONE;
        mode_nxt    = M_NAME;
      end

      if (do_take) begin
        if (pos_nxt >= PW'(NAME_BYTES)) begin
          failed_nxt = 1'b1;
        end else begin
          if (closing_nxt) begin
            // stored byte of the stack top was read ahead at this position
            if (sc_r == '0 || pos_nxt >= len_rd || name_rd != byte_value)
              differs_nxt = 1'b1;
          end else begin
            if (pos_nxt >= PW'(ROOT_LEN) || root_byte(pos_nxt[1:0]) != byte_value)
              differs_nxt = 1'b1;
            if (sc_r < SCW'(STACK_DEPTH)) begin
              name_we    = 1'b1;
              name_waddr = {sc_r[SAW-1:0], pos_nxt[NAW-1:0]};
            end
          end
          pos_nxt = pos_nxt + PW'(1);
        end
      end

      if (do_body) begin
        if (quote_r != Q_NONE) begin
          if ((quote_r == Q_SINGLE && byte_value == CH_SQUOT) ||
              (quote_r == Q_DOUBLE && byte_value == CH_DQUOT))
            quote_nxt = Q_NONE;
        end else if (byte_value == CH_SQUOT) begin
          quote_nxt = Q_SINGLE;
        end else if (byte_value == CH_DQUOT) begin
          quote_nxt = Q_DOUBLE;
        end else if (byte_value == CH_LT) begin
          failed_nxt = 1'b1;
          body_ends  = 1'b1;
        end else if (byte_value == CH_GT) begin
          body_ends = 1'b1;
          mode_nxt  = M_OUTSIDE;
          if (closing_r) begin
            if (sc_r == '0 || differs_r || pos_r != len_rd) failed_nxt = 1'b1;
            else sc_nxt = sc_r - SCW'(1);
          end else if (!root_r && (differs_r || pos_r != PW'(ROOT_LEN))) begin
            failed_nxt = 1'b1;
          end else begin
            root_nxt = 1'b1;
            if (!slash_r) begin
              if (sc_r >= SCW'(STACK_DEPTH)) begin
                failed_nxt = 1'b1;
              end else begin
                len_we = 1'b1;
                sc_nxt = sc_r + SCW'(1);
              end
            end
          end
        end
        if (!body_ends && !is_space_byte(byte_value)) slash_nxt = (byte_value == CH_SLASH);
      end
    end

    verdict = !failed_nxt && mode_nxt == M_OUTSIDE && root_nxt && sc_nxt == '0;

    // document ends: everything returns to its reset value
    if (step && last_byte) begin
      mode_nxt    = M_OUTSIDE;
      quote_nxt   = Q_NONE;
      cmatch_nxt  = 2'd0;
      sc_nxt      = '0;
      pos_nxt     = '0;
      closing_nxt = 1'b0;
      differs_nxt = 1'b0;
      slash_nxt   = 1'b0;
      root_nxt    = 1'b0;
      failed_nxt  = 1'b0;
    end
  end

  // read ahead at the stack top and name position the next byte will see
  // outside a name the next name byte is always the first one
  assign sc_m1      = sc_nxt - SCW'(1);
  assign rd_row     = (sc_nxt == '0) ? '0 : sc_m1[SAW-1:0];
  assign rd_pos     = (mode_nxt == M_NAME) ? pos_nxt[NAW-1:0] : '0;
  assign name_raddr = {rd_row, rd_pos};

  assign res.done        = step && last_byte;
  assign res.well_formed = verdict;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_OUTSIDE;
      quote_r   <= Q_NONE;
      cmatch_r  <= 2'd0;
      sc_r      <= '0;
      pos_r     <= '0;
      closing_r <= 1'b0;
      differs_r <= 1'b0;
      slash_r   <= 1'b0;
      root_r    <= 1'b0;
      failed_r  <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      quote_r   <= quote_nxt;
      cmatch_r  <= cmatch_nxt;
      sc_r      <= sc_nxt;
      pos_r     <= pos_nxt;
      closing_r <= closing_nxt;
      differs_r <= differs_nxt;
      slash_r   <= slash_nxt;
      root_r    <= root_nxt;
      failed_r  <= failed_nxt;
    end
  end

  svg_wfc_ram #(
    .DW (8),
    .AW (SAW + NAW)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (name_we),
    .wr_addr (name_waddr),
    .wr_data (byte_value),
    .rd_addr (name_raddr),
    .rd_data (name_rd)
  );

  svg_wfc_ram #(
    .DW (PW),
    .AW (SAW)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (len_we),
    .wr_addr (len_waddr),
    .wr_data (pos_r),
    .rd_addr (rd_row),
    .rd_data (len_rd)
  );

  `WFC_ASSERT(a_stack_bound, sc_r <= SCW'(STACK_DEPTH), "stack count past depth")
  `WFC_ASSERT(a_pos_bound, pos_r <= PW'(NAME_BYTES), "name position past limit")
  `WFC_IMPLY_NEXT(a_clear_after_last, step && last_byte, mode_r == M_OUTSIDE && sc_r == '0 && !failed_r && !root_r, "state not cleared after last byte")
  `WFC_IMPLY_NEXT(a_fail_sticky, failed_r && !(step && last_byte), failed_r, "failure dropped before end of document")

endmodule

@@ design/svg_well_formed_checker.sv @@
// one byte per cycle while in_tready is high; the verdict word appears in the cycle after the last byte is accepted
// each byte compares against a stored name byte read ahead from the name ram
// at the next state's stack top, so bytes can follow back to back with no gaps
// in_tready drops only while an untaken verdict sits in the output register
// rst_n is synchronous and clears scan state and output valid; rams are not cleared
// top level of the svg well-formed checker; depends on svg_wfc_pkg and svg_wfc_scan
`include "svg_well_formed_checker_macros.svh"

module svg_well_formed_checker #(
  parameter int STACK_DEPTH = svg_wfc_pkg::STACK_DEPTH_DEF,
  parameter int NAME_BYTES  = svg_wfc_pkg::NAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] well_formed, [7:1] zero
);
  import svg_wfc_pkg::*;

  wfc_res_t res;
  logic     in_fire;
  logic     out_valid_r;
  logic     wf_r;

  // a new word is taken whenever the verdict register is empty or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  svg_wfc_scan #(
    .STACK_DEPTH (STACK_DEPTH),
    .NAME_BYTES  (NAME_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_fire),
    .byte_value (in_tdata),
    .last_byte  (in_tlast),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      wf_r <= res.well_formed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, wf_r};

  `WFC_IMPLY_NEXT(a_last_gives_verdict, in_fire && in_tlast, out_valid_r, "no verdict after last byte")
  `WFC_ASSERT(a_verdict_from_last, $rose(out_valid_r) |-> $past(in_fire && in_tlast), "verdict without last byte")

endmodule

@@ dv/tb_svg_well_formed_checker.sv @@
// self-checking testbench for svg_well_formed_checker: directed documents, then random
// documents fed as a byte stream; every verdict word is checked against a fixed expected value or a local tag scanner
// depends on svg_wfc_pkg and the svg_well_formed_checker rtl
module tb_svg_well_formed_checker;
  timeunit 1ns;
  timeprecision 1ps;

  import svg_wfc_pkg::*;

  localparam int DEPTH_MAX   = STACK_DEPTH_DEF;
  localparam int NAME_MAX    = NAME_BYTES_DEF;
  localparam int HOLD_CYCLES = 200;
  // longest quiet spell: the long receiver hold plus a sender gap, taken several times over
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_BYTES  = 250;
  localparam int RAND_DOCS   = 25;
  localparam string NAME_RUN = "abcdefghijklmnopqrstuvwxyz0123456789";
  localparam logic [7:0] ROOT_TAG [3] = '{"s", "v", "g"};
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    SCAN_TEXT, SCAN_LT, SCAN_BANG, SCAN_BANG_DASH, SCAN_COMMENT,
    SCAN_CLOSE_START, SCAN_NAME, SCAN_BODY
  } scan_e;
  typedef enum logic [1:0] {QUOTE_NONE, QUOTE_SINGLE, QUOTE_DOUBLE} quote_e;
  typedef enum logic [1:0] {WANT_MODEL, WANT_BAD, WANT_GOOD} want_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    want_e      want;
  } feed_item_t;

  typedef struct {
    string text;
    want_e want;
  } doc_row_t;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata  = 8'd0;
  logic       in_tlast  = 1'b0;
  want_e      in_want   = WANT_MODEL;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  svg_well_formed_checker #(
    .STACK_DEPTH(DEPTH_MAX),
    .NAME_BYTES (NAME_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- tag scanner
  scan_e      scan_st;
  quote_e     quote_st;
  logic [1:0] dash_run;
  logic [7:0] tag_bytes [DEPTH_MAX * NAME_MAX];
  int         tag_lens [DEPTH_MAX];
  int         open_depth;
  int         name_pos;
  bit         in_close, name_miss, ends_slash, root_ok, doc_bad;

  function automatic bit tag_char(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9") ||
           b == CH_COLON || b == CH_DASH || b == CH_UNDER;
  endfunction

  function automatic bit blank_char(logic [7:0] b);
    return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic void reset_doc();
    scan_st    = SCAN_TEXT;
    quote_st   = QUOTE_NONE;
    dash_run   = 2'd0;
    open_depth = 0;
    name_pos   = 0;
    in_close   = 1'b0;
    name_miss  = 1'b0;
    ends_slash = 1'b0;
    root_ok    = 1'b0;
    doc_bad    = 1'b0;
  endfunction

  function automatic void start_name();
    name_pos   = 0;
    name_miss  = 1'b0;
    ends_slash = 1'b0;
    quote_st   = QUOTE_NONE;
    scan_st    = SCAN_NAME;
  endfunction

  function automatic void name_char(logic [7:0] b);
    if (name_pos >= NAME_MAX) begin
      doc_bad = 1'b1;
      return;
    end
    if (in_close) begin
      if (open_depth == 0 || name_pos >= tag_lens[open_depth - 1])
        name_miss = 1'b1;
      else if (tag_bytes[(open_depth - 1) * NAME_MAX + name_pos] != b)
        name_miss = 1'b1;
    end else begin
      if (name_pos >= 3 || ROOT_TAG[name_pos] != b)
        name_miss = 1'b1;
      // a name that cannot be pushed is not stored
      if (open_depth < DEPTH_MAX)
        tag_bytes[open_depth * NAME_MAX + name_pos] = b;
    end
    name_pos++;
  endfunction

  function automatic void close_tag();
    scan_st = SCAN_TEXT;
    if (in_close) begin
      if (open_depth == 0 || name_miss || name_pos != tag_lens[open_depth - 1])
        doc_bad = 1'b1;
      else
        open_depth--;
    end else if (!root_ok && (name_miss || name_pos != 3)) begin
      doc_bad = 1'b1;
    end else begin
      root_ok = 1'b1;
      if (!ends_slash) begin
        if (open_depth >= DEPTH_MAX) begin
          doc_bad = 1'b1;
        end else begin
          tag_lens[open_depth] = name_pos;
          open_depth++;
        end
      end
    end
  endfunction

  function automatic void body_char(logic [7:0] b);
    if (quote_st != QUOTE_NONE) begin
      if ((quote_st == QUOTE_SINGLE && b == CH_SQUOT) ||
          (quote_st == QUOTE_DOUBLE && b == CH_DQUOT))
        quote_st = QUOTE_NONE;
    end else if (b == CH_SQUOT) begin
      quote_st = QUOTE_SINGLE;
    end else if (b == CH_DQUOT) begin
      quote_st = QUOTE_DOUBLE;
    end else if (b == CH_LT) begin
      doc_bad = 1'b1;
      return;
    end else if (b == CH_GT) begin
      close_tag();
      return;
    end
    if (!blank_char(b))
      ends_slash = (b == CH_SLASH);
  endfunction

  // advances the scanner by one byte; returns 1 when the byte ends the document
  function automatic bit scan_byte(input logic [7:0] b, input logic lst, output logic verdict);
    verdict = 1'b0;
    if (!doc_bad) begin
      case (scan_st)
        SCAN_TEXT: begin
          if (b == CH_LT) scan_st = SCAN_LT;
        end
        SCAN_LT: begin
          if (b == CH_BANG) begin
            scan_st = SCAN_BANG;
          end else if (b == CH_SLASH) begin
            in_close = 1'b1;
            scan_st  = SCAN_CLOSE_START;
          end else if (tag_char(b)) begin
            in_close = 1'b0;
            start_name();
            name_char(b);
          end else begin
            doc_bad = 1'b1;
          end
        end
        SCAN_BANG: begin
          if (b == CH_DASH) scan_st = SCAN_BANG_DASH;
          else doc_bad = 1'b1;
        end
        SCAN_BANG_DASH: begin
          if (b == CH_DASH) begin
            scan_st  = SCAN_COMMENT;
            dash_run = 2'd0;
          end else begin
            doc_bad = 1'b1;
          end
        end
        SCAN_COMMENT: begin
          if (b == CH_DASH) begin
            if (dash_run < 2'd2) dash_run++;
          end else if (b == CH_GT && dash_run == 2'd2) begin
            scan_st  = SCAN_TEXT;
            dash_run = 2'd0;
          end else begin
            dash_run = 2'd0;
          end
        end
        SCAN_CLOSE_START: begin
          if (tag_char(b)) begin
            start_name();
            name_char(b);
          end else begin
            doc_bad = 1'b1;
          end
        end
        SCAN_NAME: begin
          if (tag_char(b)) begin
            name_char(b);
          end else begin
            scan_st = SCAN_BODY;
            body_char(b);
          end
        end
        SCAN_BODY: body_char(b);
        default: doc_bad = 1'b1;
      endcase
    end
    if (!lst) return 1'b0;
    verdict = !doc_bad && scan_st == SCAN_TEXT && root_ok && open_depth == 0;
    reset_doc();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- document builder
  logic [7:0] doc_buf [$];
  logic [7:0] open_bytes [$];
  int         open_lens [$];
  feed_item_t feed_q [$];

  // short documents whose verdict is obvious carry it; the rest go to the scanner
  doc_row_t doc_rows [22] = '{
    '{"<svg></svg>", WANT_GOOD},
    '{"<svg/>", WANT_GOOD},
    '{"x", WANT_BAD},
    '{"<svg>", WANT_BAD},
    '{"<svg></Svg>", WANT_BAD},
    '{"<SVG/>", WANT_BAD},
    '{"<g/><svg/>", WANT_BAD},
    '{"<!-- <x> --><svg/>", WANT_GOOD},
    '{"<!--->--><svg/>", WANT_MODEL},
    '{"<!DOCTYPE svg><svg/>", WANT_BAD},
    '{"<?xml?><svg/>", WANT_BAD},
    '{"<svg a='>' b=\"<'\" />", WANT_MODEL},
    '{"<svg <g/>", WANT_BAD},
    '{"</svg>", WANT_BAD},
    '{"<svg><g:a-b_1 x=\"1\"/><p></p></svg >", WANT_MODEL},
    '{"<svg\t\n\v\f\015/>", WANT_MODEL},
    '{"<svg a/b>", WANT_MODEL},
    '{"<svg><!-- x", WANT_BAD},
    '{"<svg/><", WANT_BAD},
    '{"<svg>< g>", WANT_BAD},
    '{"<svg><ab></abc></svg>", WANT_BAD},
    '{"<svg><abc></ab></svg>", WANT_BAD}
  };

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) doc_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_LT) ? CH_GT : b;
  endfunction

  function automatic void put_nest(int n);
    put_text("<svg>");
    repeat (n) put_text("<g>");
    repeat (n) put_text("</g>");
    put_text("</svg>");
  endfunction

  // appends a name and returns its length; now and then longer than the name limit
  function automatic int put_name();
    string pool [6] = '{"g", "path", "svg", "a:b", "x-1", "_Q9"};
    string s;
    int len;
    if ($urandom_range(0, 1) == 0) begin
      s = pool[$urandom_range(0, 5)];
      put_text(s);
      return s.len();
    end
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(NAME_MAX - 2, NAME_MAX + 2)
                                       : $urandom_range(1, 6);
    repeat (len) doc_buf.push_back(pick("abgsvzAMZ0579:-_"));
    return len;
  endfunction

  function automatic void put_attrs();
    logic [7:0] q;
    repeat ($urandom_range(0, 2)) begin
      doc_buf.push_back(pick(" \t\n"));
      void'(put_name());
      doc_buf.push_back("=");
      q = ($urandom_range(0, 1) == 0) ? CH_SQUOT : CH_DQUOT;
      doc_buf.push_back(q);
      repeat ($urandom_range(0, 4))
        doc_buf.push_back(q == CH_SQUOT ? pick("a />< =\"") : pick("a />< ='"));
      doc_buf.push_back(q);
    end
    if ($urandom_range(0, 2) == 0) doc_buf.push_back(CH_SPACE);
  endfunction

  function automatic void put_element(bit self_close);
    int len;
    doc_buf.push_back(CH_LT);
    len = put_name();
    if (!self_close) begin
      for (int i = doc_buf.size() - len; i < doc_buf.size(); i++)
        open_bytes.push_back(doc_buf[i]);
      open_lens.push_back(len);
    end
    put_attrs();
    if (self_close) put_text("/>");
    else doc_buf.push_back(CH_GT);
  endfunction

  function automatic void put_close();
    int len;
    len = open_lens.pop_back();
    put_text("</");
    for (int i = open_bytes.size() - len; i < open_bytes.size(); i++)
      doc_buf.push_back(open_bytes[i]);
    repeat (len) void'(open_bytes.pop_back());
    if ($urandom_range(0, 3) == 0) doc_buf.push_back(pick(" \t"));
    doc_buf.push_back(CH_GT);
  endfunction

  function automatic void put_filler();
    if ($urandom_range(0, 2) == 0) begin
      put_text("<!--");
      repeat ($urandom_range(0, 5)) doc_buf.push_back(pick("-> a<"));
      put_text("-->");
    end else begin
      repeat ($urandom_range(1, 4)) doc_buf.push_back(text_byte());
    end
  endfunction

  // mostly well-formed trees with random names and attributes, some damaged, some noise
  function automatic void rand_doc();
    int pos;
    doc_buf.delete();
    open_bytes.delete();
    open_lens.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10))
        doc_buf.push_back(($urandom_range(0, 1) == 0) ? pick("<>/!-?'\"svg ")
                                                      : 8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) put_filler();
    if ($urandom_range(0, 24) == 0) begin
      put_nest($urandom_range(DEPTH_MAX - 4, DEPTH_MAX + 1));
    end else begin
      put_text("<svg");
      put_attrs();
      if ($urandom_range(0, 4) == 0) begin
        put_text("/>");
      end else begin
        doc_buf.push_back(CH_GT);
        put_text("svg");
        repeat (3) open_bytes.push_back(doc_buf[doc_buf.size() - 3 + open_bytes.size()]);
        repeat (3) void'(doc_buf.pop_back());
        open_lens.push_back(3);
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 3))
            0: put_filler();
            1: put_element(1'b1);
            2: begin
              if (open_lens.size() < 4) put_element(1'b0);
              else put_close();
            end
            default: begin
              if (open_lens.size() > 1) put_close();
              else put_element(1'b1);
            end
          endcase
        end
        while (open_lens.size() != 0) put_close();
      end
    end
    if ($urandom_range(0, 3) == 0) put_filler();
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, doc_buf.size() - 1);
      case ($urandom_range(0, 3))
        0: doc_buf[pos] = 8'($urandom_range(0, 255));
        1: begin
          if (doc_buf.size() > 1) doc_buf.delete(pos);
        end
        2: begin
          while (doc_buf.size() > pos + 1) void'(doc_buf.pop_back());
        end
        default: doc_buf.insert(pos, pick("<>/!-'\"aA "));
      endcase
    end
  endfunction

  function automatic void commit_doc(want_e want);
    feed_item_t it;
    foreach (doc_buf[i]) begin
      it.data = doc_buf[i];
      it.last = (i == doc_buf.size() - 1);
      it.want = it.last ? want : WANT_MODEL;
      feed_q.push_back(it);
    end
    doc_buf.delete();
  endfunction

  // ---------------------------------------------------------------- checking
  logic pending_verdicts [$];
  int   verdicts_seen = 0;
  int   mismatches    = 0;
  int   idle_cycles   = 0;
  bit   quiet_tail    = 1'b0;

  always @(posedge clk) begin
    logic verdict;
    logic want_bit;
    bit   took;
    if (rst_n) begin
      took = 1'b0;
      if (in_tvalid && in_tready) begin
        took = 1'b1;
        if (scan_byte(in_tdata, in_tlast, verdict)) begin
          case (in_want)
            WANT_GOOD: pending_verdicts.push_back(1'b1);
            WANT_BAD:  pending_verdicts.push_back(1'b0);
            default:   pending_verdicts.push_back(verdict);
          endcase
        end
      end
      if (out_tvalid && out_tready) begin
        took = 1'b1;
        verdicts_seen++;
        if (pending_verdicts.size() == 0) begin
          $error("verdict word %h with no document pending", out_tdata);
          mismatches++;
        end else begin
          want_bit = pending_verdicts.pop_front();
          if (out_tdata[0] !== want_bit) begin
            $error("well_formed: expected %0b, got %0b", want_bit, out_tdata[0]);
            mismatches++;
          end
          if (out_tdata[7:1] !== 7'd0) begin
            $error("pad bits: expected 00, got %h", out_tdata[7:1]);
            mismatches++;
          end
        end
      end
      idle_cycles = took ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    bit rx_gappy;
    bit held_long;
    rx_gappy  = 1'b1;
    held_long = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_long && verdicts_seen >= 12) begin
        // long back-pressure so the verdict register fills and the input stalls
        held_long = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet_tail && rx_gappy && $urandom_range(0, 1) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
      if ($urandom_range(0, 19) == 0) rx_gappy = !rx_gappy;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    feed_item_t item;
    bit gappy;
    bit new_doc;
    int tail_len;
    int rand_bytes;
    int rand_docs;

    reset_doc();
    foreach (doc_rows[r]) begin
      put_text(doc_rows[r].text);
      commit_doc(doc_rows[r].want);
    end
    // zero and all-ones bytes, one outside a tag and one in the tag body
    doc_buf.push_back(8'h00);
    put_text("<svg");
    doc_buf.push_back(8'hFF);
    put_text("/>");
    commit_doc(WANT_MODEL);
    // name exactly at the limit, then one byte over
    for (int n = NAME_MAX; n <= NAME_MAX + 1; n++) begin
      put_text("<svg><");
      for (int i = 0; i < n; i++) doc_buf.push_back(NAME_RUN[i]);
      put_text("></");
      for (int i = 0; i < n; i++) doc_buf.push_back(NAME_RUN[i]);
      put_text("></svg>");
      commit_doc(n > NAME_MAX ? WANT_BAD : WANT_GOOD);
    end
    // stack filled exactly, then one push past it
    put_nest(DEPTH_MAX - 1);
    commit_doc(WANT_GOOD);
    put_text("<svg>");
    repeat (DEPTH_MAX) put_text("<g>");
    commit_doc(WANT_BAD);

    rand_bytes = 0;
    rand_docs  = 0;
    while (rand_bytes < RAND_BYTES || rand_docs < RAND_DOCS) begin
      rand_doc();
      rand_bytes += doc_buf.size();
      rand_docs++;
      commit_doc(WANT_MODEL);
    end
    tail_len = feed_q.size() / 8;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gappy   = 1'b0;
    new_doc = 1'b1;
    while (feed_q.size() != 0) begin
      item = feed_q.pop_front();
      if (new_doc) gappy = ($urandom_range(0, 2) != 0);
      new_doc    = item.last;
      quiet_tail = (feed_q.size() < tail_len);
      if (gappy && !quiet_tail && $urandom_range(0, 3) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= item.data;
      in_tlast  <= item.last;
      in_want   <= item.want;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
